FILE: hw/rtl/lzd_pkg.sv
package lzd_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int WIN_AW      = $clog2(WINDOW_SIZE);
   localparam int FILL_W      = WIN_AW + 1;
   localparam logic [WIN_AW-1:0] WIN_START = WIN_AW'(12'hFEE);
   localparam int LEN_BIAS    = 3;
   localparam int REM_W       = 5;

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_MATCH,
      CMD_END
   } cmd_kind_type;

   // One decoded token handed from the parser to the copy engine.
   typedef struct packed {
      cmd_kind_type      kind;
      logic [7:0]        lit;
      logic [WIN_AW-1:0] offset;
      logic [3:0]        len_code;
      logic              stream_end;
   } cmd_type;

endpackage

FILE: hw/rtl/lzd_ifs.sv
interface lzd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface lzd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: hw/rtl/lzd_parser.sv
module lzd_parser
   import lzd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lzd_req_if.sink     req_bus,
   input  logic        cmd_full,
   output logic        cmd_push,
   output cmd_type     cmd_data
);

   logic [7:0] flag_ff, flag_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic       phase_ff, phase_in;
   logic [7:0] offset_low_ff, offset_low_in;
   logic       accept;
   logic       has_cmd;

   assign req_bus.ready = !cmd_full;

   always_comb begin
      accept        = req_bus.valid & req_bus.ready;
      flag_in       = flag_ff;
      bit_index_in  = bit_index_ff;
      phase_in      = phase_ff;
      offset_low_in = offset_low_ff;
      has_cmd       = 1'b0;

      cmd_data.kind       = CMD_END;
      cmd_data.lit        = req_bus.in_byte;
      cmd_data.offset     = {req_bus.in_byte[7:4], offset_low_ff};
      cmd_data.len_code   = req_bus.in_byte[3:0];
      cmd_data.stream_end = req_bus.stream_end;

      if (accept) begin
         if (bit_index_ff[3]) begin
            // new flag byte
            flag_in      = req_bus.in_byte;
            bit_index_in = '0;
            phase_in     = 1'b0;
         end else if (!phase_ff) begin
            if (flag_ff[bit_index_ff[2:0]]) begin
               has_cmd       = 1'b1;
               cmd_data.kind = CMD_LIT;
               bit_index_in  = bit_index_ff + 4'd1;
            end else begin
               offset_low_in = req_bus.in_byte;
               phase_in      = 1'b1;
            end
         end else begin
            has_cmd       = 1'b1;
            cmd_data.kind = CMD_MATCH;
            phase_in      = 1'b0;
            bit_index_in  = bit_index_ff + 4'd1;
         end

         // drop any partial token and start over for the next stream
         if (req_bus.stream_end) begin
            flag_in       = '0;
            bit_index_in  = 4'd8;
            phase_in      = 1'b0;
            offset_low_in = '0;
         end
      end

      cmd_push = accept & (has_cmd | req_bus.stream_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff       <= '0;
         bit_index_ff  <= 4'd8;
         phase_ff      <= 1'b0;
         offset_low_ff <= '0;
      end else begin
         flag_ff       <= flag_in;
         bit_index_ff  <= bit_index_in;
         phase_ff      <= phase_in;
         offset_low_ff <= offset_low_in;
      end
   end

endmodule

FILE: hw/rtl/lzd_cmd_fifo.sv
module lzd_cmd_fifo
   import lzd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type              entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      full      = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
      empty     = (count_ff == '0);
      head      = entry_ff[rd_ptr_ff];
      do_push   = push & !full;
      do_pop    = pop & !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/lzd_copy_engine.sv
module lzd_copy_engine
   import lzd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       empty,
   output logic       pop,
   lzd_rsp_if.source  rsp_bus
);

   logic [7:0] window_mem [WINDOW_SIZE];

   // copy run in progress
   logic              active_ff, active_in;
   logic [WIN_AW-1:0] src_ff, src_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              cmd_end_ff, cmd_end_in;

   // window write side
   logic [WIN_AW-1:0] wr_pos_ff, wr_pos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // fetch stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_is_lit_ff;
   logic [7:0]        s1_lit_ff;
   logic              s1_hit_ff;
   logic [7:0]        s1_hit_data_ff;
   logic              s1_ent_ff;
   logic              s1_last_ff;
   logic              s1_end_ff;
   logic [7:0]        rdata_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              adv;
   logic              issue_ok;
   logic              issue;
   logic              issue_lit;
   logic              issue_last;
   logic              issue_end;
   logic              end_now;
   logic              restart;
   logic [WIN_AW-1:0] rd_addr;
   logic [WIN_AW-1:0] rd_dist;
   logic              issue_hit;
   logic              issue_ent;
   logic [7:0]        wdata;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.run_last = rsp_last_ff;

   always_comb begin
      out_free = !rsp_valid_ff | rsp_bus.ready;
      adv      = s1_valid_ff & out_free;
      issue_ok = !s1_valid_ff | out_free;

      if (s1_is_lit_ff) begin
         wdata = s1_lit_ff;
      end else if (s1_hit_ff) begin
         wdata = s1_hit_data_ff;
      end else if (s1_ent_ff) begin
         wdata = rdata_ff;
      end else begin
         wdata = '0;
      end

      issue      = 1'b0;
      issue_lit  = 1'b0;
      issue_last = 1'b0;
      issue_end  = 1'b0;
      end_now    = 1'b0;
      pop        = 1'b0;
      rd_addr    = src_ff;
      active_in  = active_ff;
      src_in     = src_ff;
      rem_in     = rem_ff;
      cmd_end_in = cmd_end_ff;

      if (active_ff) begin
         if (issue_ok) begin
            issue      = 1'b1;
            issue_last = (rem_ff == REM_W'(1));
            issue_end  = issue_last & cmd_end_ff;
            src_in     = src_ff + 1'b1;
            rem_in     = rem_ff - 1'b1;
            if (issue_last) begin
               active_in = 1'b0;
            end
         end
      end else if (!empty) begin
         case (head.kind)
            CMD_LIT: begin
               if (issue_ok) begin
                  issue      = 1'b1;
                  issue_lit  = 1'b1;
                  issue_last = 1'b1;
                  issue_end  = head.stream_end;
                  pop        = 1'b1;
               end
            end
            CMD_MATCH: begin
               if (issue_ok) begin
                  issue      = 1'b1;
                  rd_addr    = head.offset;
                  active_in  = 1'b1;
                  src_in     = head.offset + 1'b1;
                  rem_in     = REM_W'(head.len_code) + REM_W'(LEN_BIAS - 1);
                  cmd_end_in = head.stream_end;
                  pop        = 1'b1;
               end
            end
            CMD_END: begin
               // wait until the last byte of the stream is in the window
               if (!s1_valid_ff) begin
                  end_now = 1'b1;
                  pop     = 1'b1;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end

      // a byte written this cycle is not yet visible at the memory read port
      restart   = end_now | (adv & s1_end_ff);
      issue_hit = adv & !s1_end_ff & !issue_lit & (wr_pos_ff == rd_addr);
      rd_dist   = rd_addr - WIN_START;
      issue_ent = !(adv & s1_end_ff) & (FILL_W'(rd_dist) < fill_ff);

      wr_pos_in = wr_pos_ff;
      fill_in   = fill_ff;
      if (restart) begin
         wr_pos_in = WIN_START;
         fill_in   = '0;
      end else if (adv) begin
         wr_pos_in = wr_pos_ff + 1'b1;
         if (fill_ff != FILL_W'(WINDOW_SIZE)) begin
            fill_in = fill_ff + 1'b1;
         end
      end

      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         src_ff       <= '0;
         rem_ff       <= '0;
         cmd_end_ff   <= 1'b0;
         wr_pos_ff    <= WIN_START;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         src_ff       <= src_in;
         rem_ff       <= rem_in;
         cmd_end_ff   <= cmd_end_in;
         wr_pos_ff    <= wr_pos_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_is_lit_ff   <= issue_lit;
         s1_lit_ff      <= head.lit;
         s1_hit_ff      <= issue_hit;
         s1_hit_data_ff <= wdata;
         s1_ent_ff      <= issue_ent;
         s1_last_ff     <= issue_last;
         s1_end_ff      <= issue_end;
      end
      if (adv) begin
         rsp_byte_ff <= wdata;
         rsp_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         window_mem[wr_pos_ff] <= wdata;
      end
      if (issue && !issue_lit) begin
         rdata_ff <= window_mem[rd_addr];
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_SIZE))
      else $error("window fill count out of range");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (rem_ff != '0))
      else $error("copy run active with nothing left");

   a_end_drained: assert property (@(posedge clock) disable iff (reset)
      end_now |-> !s1_valid_ff && !active_ff)
      else $error("stream restart while bytes still in flight");

   a_restart_pos: assert property (@(posedge clock) disable iff (reset)
      restart |=> (wr_pos_ff == WIN_START) && (fill_ff == '0))
      else $error("window pointer not restored at stream end");

   a_hit_match_only: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_hit_ff) |-> !s1_is_lit_ff)
      else $error("forwarded data on a literal beat");
`endif

endmodule

FILE: hw/rtl/lzss_decompressor_core.sv
// LZSS decoder with a 4096-byte history window.
// req_bus carries one compressed byte per beat (in_byte) and stream_end,
// which marks the final byte of a stream. rsp_bus returns decoded bytes,
// one per beat; run_last is set on the last byte produced by one input beat.
// A flag byte, the offset byte of a match, and a cut-off token give no beats.
// Throughput: the parser takes one input beat per cycle while its four-entry
// token queue has room. The copy engine produces one output byte per cycle
// while rsp_bus is ready, through a window memory with one write and one read
// port, so a literal yields one byte and a match yields 3 to 18 bytes.
// An accepted literal passes through the token queue, the fetch stage and
// the output register to its rsp beat; a match's first byte takes the same path.
// At the end of a stream the window pointer and fill count return to their
// start values once the last byte is written; unwritten window entries read
// as zero, so no clearing pass is needed and the next stream starts at once.
// Reset is synchronous and clears the parser, queue and engine control state.
// When rsp_bus is stalled the output register holds, the engine stops, and
// the queue fills; req_bus then deasserts ready until space frees up.
module lzss_decompressor_core
   import lzd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lzd_req_if.sink    req_bus,
   lzd_rsp_if.source  rsp_bus
);

   logic    cmd_push;
   cmd_type cmd_data;
   logic    cmd_full;
   logic    cmd_pop;
   cmd_type cmd_head;
   logic    cmd_empty;

   lzd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   lzd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   lzd_copy_engine u_copy_engine (
      .clock   (clock),
      .reset   (reset),
      .head    (cmd_head),
      .empty   (cmd_empty),
      .pop     (cmd_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
